// ===== rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, widths and helpers for the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int PHYS_LIMIT_BITS = 39;
   localparam int FRAME_BITS      = 40;
   localparam int PAGE_BITS       = 12;
   localparam int ENTRY_ADDR_BITS = FRAME_BITS + PAGE_BITS;
   localparam int LINEAR_BITS     = 48;
   localparam int ADDR_BITS       = 64;
   localparam int RD_ADDR_BITS    = 39;
   localparam int INDEX_BITS      = 9;
   localparam int CSR_DATA_BITS   = FRAME_BITS;

   localparam logic [ENTRY_ADDR_BITS:0] ENTRY_LIMIT =
      (ENTRY_ADDR_BITS+1)'(1) << PHYS_LIMIT_BITS;

   localparam int PRESENT_BIT = 0;
   localparam int LARGE_BIT   = 7;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FAULT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE        = 2'd0,
      FAULT_NOT_MAPPED  = 2'd1,
      FAULT_UNREACHABLE = 2'd2,
      FAULT_UNEXPECTED  = 2'd3
   } fault_type;

   typedef enum logic [1:0] {
      CSR_PAGING_ENABLED  = 2'd0,
      CSR_FIVE_LEVEL_MODE = 2'd1,
      CSR_ROOT_FRAME      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      LEVEL_TOP  = 2'd0,
      LEVEL_PDPT = 2'd1,
      LEVEL_DIR  = 2'd2,
      LEVEL_LEAF = 2'd3
   } level_type;

   typedef enum logic {
      REQ_TRANSLATE = 1'b0,
      REQ_RESPONSE  = 1'b1
   } req_kind_type;

   function automatic logic [INDEX_BITS-1:0] level_index(
      input logic [LINEAR_BITS-1:0] linear,
      input logic [1:0]             level
   );
      logic [INDEX_BITS-1:0] idx;
      case (level)
         LEVEL_TOP:  idx = linear[47:39];
         LEVEL_PDPT: idx = linear[38:30];
         LEVEL_DIR:  idx = linear[29:21];
         default:    idx = linear[20:12];
      endcase
      return idx;
   endfunction

   function automatic logic [ADDR_BITS-1:0] offset_mask(input logic [1:0] level);
      logic [ADDR_BITS-1:0] m;
      case (level)
         LEVEL_PDPT: m = ADDR_BITS'(64'h3fff_ffff);
         LEVEL_DIR:  m = ADDR_BITS'(64'h1f_ffff);
         LEVEL_LEAF: m = ADDR_BITS'(64'hfff);
         default:    m = '0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/ptw_req_if.sv =====
// ----------------------------------------------------------------------------
// ptw_req_if
// Request channel: translate requests and entry read responses.
// ----------------------------------------------------------------------------
interface ptw_req_if;

   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [ptw_pkg::ADDR_BITS-1:0]  linear_address;
   logic [ptw_pkg::ADDR_BITS-1:0]  entry_data;
   logic                           read_failed;

   modport source (
      output valid, req_type, linear_address, entry_data, read_failed,
      input  ready
   );

   modport sink (
      input  valid, req_type, linear_address, entry_data, read_failed,
      output ready
   );

endinterface

// ===== rtl/ptw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ptw_rsp_if
// Result channel: entry read requests, completed translations and faults.
// ----------------------------------------------------------------------------
interface ptw_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [1:0]                       result_kind;
   logic [ptw_pkg::RD_ADDR_BITS-1:0] read_address;
   logic [ptw_pkg::ADDR_BITS-1:0]    physical_address;
   logic [1:0]                       fault_code;
   logic [1:0]                       fault_level;

   modport source (
      output valid, result_kind, read_address, physical_address, fault_code,
             fault_level,
      input  ready
   );

   modport sink (
      input  valid, result_kind, read_address, physical_address, fault_code,
             fault_level,
      output ready
   );

endinterface

// ===== rtl/four_level_page_table_walker_core.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Walks four levels of 8-byte page table entries to translate a linear
// address; emits entry reads, completions and faults, one result per beat.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      beat
//  req_bus   in    valid/ready    translate request or entry read response
//  rsp_bus   out   valid/ready    entry read, translation done, or fault
//  csr_*     in    write enable   register write, index + data
//
//  One beat per cycle sustained while rsp is not stalled; the rsp beat passes
//  the input register, then check/address logic into the result register.
//  Reset clears registers, walk state and both pipeline stages.
//  A stalled rsp holds the result register; req still takes one beat into
//  the empty input register, then ready drops until rsp drains.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core (
   input  logic                               clock,
   input  logic                               reset,
   ptw_req_if.sink                            req_bus,
   ptw_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [1:0]                         csr_index,
   input  logic [ptw_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   // configuration
   logic                                paging_ff;
   logic                                five_level_ff;
   logic [ptw_pkg::FRAME_BITS-1:0]      root_frame_ff;

   // input stage
   logic                                s1_valid_ff;
   logic                                s1_req_type_ff;
   logic [ptw_pkg::ADDR_BITS-1:0]       s1_linear_ff;
   logic [ptw_pkg::ADDR_BITS-1:0]       s1_entry_ff;
   logic                                s1_failed_ff;

   // walk state
   logic                                active_ff, active_in;
   logic [1:0]                          level_ff, level_in;
   logic [ptw_pkg::FRAME_BITS-1:0]      frame_ff, frame_in;
   logic [ptw_pkg::LINEAR_BITS-1:0]     saved_ff, saved_in;

   // result stage
   logic                                out_valid_ff;
   logic [1:0]                          kind_ff, kind_in;
   logic [ptw_pkg::RD_ADDR_BITS-1:0]    rd_addr_ff, rd_addr_in;
   logic [ptw_pkg::ADDR_BITS-1:0]       pa_ff, pa_in;
   logic [1:0]                          code_ff, code_in;
   logic [1:0]                          flt_level_ff, flt_level_in;

   logic                                advance;
   logic                                process;
   logic                                issue;
   logic [1:0]                          req_level;
   logic [ptw_pkg::FRAME_BITS-1:0]      req_frame;
   logic [ptw_pkg::FRAME_BITS-1:0]      entry_frame;
   logic [ptw_pkg::ENTRY_ADDR_BITS-1:0] entry_at;
   logic [ptw_pkg::ADDR_BITS-1:0]       mask;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign process       = s1_valid_ff && advance;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign entry_frame   = s1_entry_ff[ptw_pkg::ENTRY_ADDR_BITS-1:ptw_pkg::PAGE_BITS];
   assign mask          = ptw_pkg::offset_mask(level_ff);

   always_comb begin
      active_in    = active_ff;
      level_in     = level_ff;
      frame_in     = frame_ff;
      saved_in     = saved_ff;
      kind_in      = ptw_pkg::KIND_DONE;
      rd_addr_in   = '0;
      pa_in        = '0;
      code_in      = ptw_pkg::FAULT_NONE;
      flt_level_in = ptw_pkg::LEVEL_TOP;
      issue        = 1'b0;
      req_level    = level_ff;
      req_frame    = frame_ff;
      entry_at     = '0;

      if (s1_req_type_ff == ptw_pkg::REQ_TRANSLATE) begin
         active_in = 1'b0;
         if (five_level_ff) begin
            kind_in = ptw_pkg::KIND_FAULT;
            code_in = ptw_pkg::FAULT_NOT_MAPPED;
         end else if (!paging_ff) begin
            pa_in = s1_linear_ff;
         end else begin
            saved_in  = s1_linear_ff[ptw_pkg::LINEAR_BITS-1:0];
            issue     = 1'b1;
            req_frame = root_frame_ff;
            req_level = ptw_pkg::LEVEL_TOP;
         end
      end else if (!active_ff) begin
         kind_in = ptw_pkg::KIND_FAULT;
         code_in = ptw_pkg::FAULT_UNEXPECTED;
      end else if (s1_failed_ff) begin
         active_in    = 1'b0;
         kind_in      = ptw_pkg::KIND_FAULT;
         code_in      = ptw_pkg::FAULT_UNREACHABLE;
         flt_level_in = level_ff;
      end else if (!s1_entry_ff[ptw_pkg::PRESENT_BIT]) begin
         active_in    = 1'b0;
         kind_in      = ptw_pkg::KIND_FAULT;
         code_in      = ptw_pkg::FAULT_NOT_MAPPED;
         flt_level_in = level_ff;
      end else if (level_ff == ptw_pkg::LEVEL_LEAF
                   || (level_ff != ptw_pkg::LEVEL_TOP && s1_entry_ff[ptw_pkg::LARGE_BIT])) begin
         active_in = 1'b0;
         pa_in     = ({{(ptw_pkg::ADDR_BITS-ptw_pkg::ENTRY_ADDR_BITS){1'b0}}, entry_frame,
                       {ptw_pkg::PAGE_BITS{1'b0}}} & ~mask)
                   | ({{(ptw_pkg::ADDR_BITS-ptw_pkg::LINEAR_BITS){1'b0}}, saved_ff} & mask);
      end else begin
         issue     = 1'b1;
         req_frame = entry_frame;
         req_level = level_ff + 2'd1;
      end

      if (issue) begin
         level_in = req_level;
         frame_in = req_frame;
         entry_at = {req_frame, ptw_pkg::level_index(saved_in, req_level), 3'b000};
         if ({1'b0, entry_at} < ptw_pkg::ENTRY_LIMIT) begin
            active_in  = 1'b1;
            kind_in    = ptw_pkg::KIND_READ;
            rd_addr_in = entry_at[ptw_pkg::RD_ADDR_BITS-1:0];
         end else begin
            active_in    = 1'b0;
            kind_in      = ptw_pkg::KIND_FAULT;
            code_in      = ptw_pkg::FAULT_UNREACHABLE;
            flt_level_in = req_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_ff     <= 1'b0;
         five_level_ff <= 1'b0;
         root_frame_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ptw_pkg::CSR_PAGING_ENABLED:  paging_ff     <= csr_write_data[0];
            ptw_pkg::CSR_FIVE_LEVEL_MODE: five_level_ff <= csr_write_data[0];
            ptw_pkg::CSR_ROOT_FRAME:      root_frame_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_req_type_ff <= req_bus.req_type;
         s1_linear_ff   <= req_bus.linear_address;
         s1_entry_ff    <= req_bus.entry_data;
         s1_failed_ff   <= req_bus.read_failed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         level_ff  <= ptw_pkg::LEVEL_TOP;
         frame_ff  <= '0;
         saved_ff  <= '0;
      end else if (process) begin
         active_ff <= active_in;
         level_ff  <= level_in;
         frame_ff  <= frame_in;
         saved_ff  <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         kind_ff      <= kind_in;
         rd_addr_ff   <= rd_addr_in;
         pa_ff        <= pa_in;
         code_ff      <= code_in;
         flt_level_ff <= flt_level_in;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.result_kind      = kind_ff;
   assign rsp_bus.read_address     = rd_addr_ff;
   assign rsp_bus.physical_address = pa_ff;
   assign rsp_bus.fault_code       = code_ff;
   assign rsp_bus.fault_level      = flt_level_ff;

endmodule

// ===== rtl/ptw_checker.sv =====
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks on the walker's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       result_kind,
   input logic [ptw_pkg::RD_ADDR_BITS-1:0] read_address,
   input logic [ptw_pkg::ADDR_BITS-1:0]    physical_address,
   input logic [1:0]                       fault_code,
   input logic [1:0]                       fault_level
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind)
         && $stable(read_address) && $stable(physical_address))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> result_kind == ptw_pkg::KIND_READ
         || result_kind == ptw_pkg::KIND_DONE || result_kind == ptw_pkg::KIND_FAULT)
      else $error("illegal result kind");

   a_fault_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (result_kind == ptw_pkg::KIND_FAULT)
         == (fault_code != ptw_pkg::FAULT_NONE)
         && (result_kind == ptw_pkg::KIND_FAULT || fault_level == ptw_pkg::LEVEL_TOP))
      else $error("fault fields disagree with result kind");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == ptw_pkg::KIND_READ
         |-> physical_address == '0 && read_address[2:0] == 3'b000)
      else $error("entry read with stray address bits");

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .result_kind      (rsp_bus.result_kind),
   .read_address     (rsp_bus.read_address),
   .physical_address (rsp_bus.physical_address),
   .fault_code       (rsp_bus.fault_code),
   .fault_level      (rsp_bus.fault_level)
);

// ===== bench/ptw_walk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptw_walk_checker
// Watches the request, result and register ports of the page table walker,
// predicts the result of every accepted request beat, and checks each
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ptw_walk_checker (
   input  logic                              clock,
   input  logic                              reset,
   ptw_req_if                                req_mon,
   ptw_rsp_if                                rsp_mon,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [ptw_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   output int                                mismatch_count,
   output int                                outcomes_in_flight
);

   typedef struct packed {
      ptw_pkg::kind_type                  kind;
      logic [ptw_pkg::RD_ADDR_BITS-1:0]   read_address;
      logic [ptw_pkg::ADDR_BITS-1:0]      physical_address;
      ptw_pkg::fault_type                 fault_code;
      ptw_pkg::level_type                 fault_level;
   } walk_outcome_type;

   logic                             paging_on;
   logic                             five_level;
   logic [ptw_pkg::FRAME_BITS-1:0]   root_pfn;
   logic                             walking;
   ptw_pkg::level_type               walk_lvl;
   logic [ptw_pkg::FRAME_BITS-1:0]   table_pfn;
   logic [ptw_pkg::LINEAR_BITS-1:0]  walk_linear;
   walk_outcome_type                 walk_outcomes[$];

   function automatic walk_outcome_type fault_outcome(input ptw_pkg::fault_type code,
                                                      input ptw_pkg::level_type lvl);
      walk_outcome_type r;
      r = '0;
      r.kind = ptw_pkg::KIND_FAULT;
      r.fault_code = code;
      r.fault_level = lvl;
      walking = 1'b0;
      return r;
   endfunction

   function automatic walk_outcome_type fetch_entry();
      walk_outcome_type r;
      logic [ptw_pkg::INDEX_BITS-1:0] idx;
      logic [52:0] at;
      r = '0;
      idx = ptw_pkg::INDEX_BITS'(walk_linear >> (39 - 9 * int'(walk_lvl)));
      at = {1'b0, table_pfn, 12'h000} + {41'h0, idx, 3'b000};
      if (at >= (53'd1 << ptw_pkg::PHYS_LIMIT_BITS)) begin
         r = fault_outcome(ptw_pkg::FAULT_UNREACHABLE, walk_lvl);
      end else begin
         walking = 1'b1;
         r.kind = ptw_pkg::KIND_READ;
         r.read_address = at[ptw_pkg::RD_ADDR_BITS-1:0];
      end
      return r;
   endfunction

   function automatic walk_outcome_type walk_step(
      input logic                          kind_bit,
      input logic [ptw_pkg::ADDR_BITS-1:0] linear,
      input logic [ptw_pkg::ADDR_BITS-1:0] entry,
      input logic                          failed
   );
      walk_outcome_type r;
      logic [ptw_pkg::FRAME_BITS-1:0] pfn;
      logic [ptw_pkg::ADDR_BITS-1:0] offs_mask;
      r = '0;
      if (kind_bit == ptw_pkg::REQ_TRANSLATE) begin
         walking = 1'b0;
         if (five_level) begin
            r = fault_outcome(ptw_pkg::FAULT_NOT_MAPPED, ptw_pkg::LEVEL_TOP);
         end else if (!paging_on) begin
            r.kind = ptw_pkg::KIND_DONE;
            r.physical_address = linear;
         end else begin
            walk_linear = linear[ptw_pkg::LINEAR_BITS-1:0];
            walk_lvl = ptw_pkg::LEVEL_TOP;
            table_pfn = root_pfn;
            r = fetch_entry();
         end
      end else if (!walking) begin
         r = fault_outcome(ptw_pkg::FAULT_UNEXPECTED, ptw_pkg::LEVEL_TOP);
      end else if (failed) begin
         r = fault_outcome(ptw_pkg::FAULT_UNREACHABLE, walk_lvl);
      end else if (!entry[ptw_pkg::PRESENT_BIT]) begin
         r = fault_outcome(ptw_pkg::FAULT_NOT_MAPPED, walk_lvl);
      end else begin
         pfn = entry[51:12];
         if (walk_lvl == ptw_pkg::LEVEL_LEAF
             || (walk_lvl != ptw_pkg::LEVEL_TOP && entry[ptw_pkg::LARGE_BIT])) begin
            case (walk_lvl)
               ptw_pkg::LEVEL_PDPT: offs_mask = 64'h3fff_ffff;
               ptw_pkg::LEVEL_DIR:  offs_mask = 64'h1f_ffff;
               default:             offs_mask = 64'hfff;
            endcase
            walking = 1'b0;
            r.kind = ptw_pkg::KIND_DONE;
            r.physical_address = ({12'h0, pfn, 12'h000} & ~offs_mask)
                               | ({16'h0, walk_linear} & offs_mask);
         end else begin
            table_pfn = pfn;
            walk_lvl = ptw_pkg::level_type'(walk_lvl + 2'd1);
            r = fetch_entry();
         end
      end
      return r;
   endfunction

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : track
      walk_outcome_type want;
      if (reset) begin
         paging_on = 1'b0;
         five_level = 1'b0;
         root_pfn = '0;
         walking = 1'b0;
         walk_lvl = ptw_pkg::LEVEL_TOP;
         table_pfn = '0;
         walk_linear = '0;
         walk_outcomes.delete();
         mismatch_count = 0;
         outcomes_in_flight <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (walk_outcomes.size() == 0) begin
               $error("result beat with nothing predicted: kind %0d", rsp_mon.result_kind);
               mismatch_count++;
            end else begin
               want = walk_outcomes.pop_front();
               if (rsp_mon.result_kind !== want.kind)
                  note_mismatch("result_kind", 64'(want.kind), 64'(rsp_mon.result_kind));
               if (rsp_mon.read_address !== want.read_address)
                  note_mismatch("read_address", 64'(want.read_address),
                                64'(rsp_mon.read_address));
               if (rsp_mon.physical_address !== want.physical_address)
                  note_mismatch("physical_address", want.physical_address,
                                rsp_mon.physical_address);
               if (rsp_mon.fault_code !== want.fault_code)
                  note_mismatch("fault_code", 64'(want.fault_code), 64'(rsp_mon.fault_code));
               if (rsp_mon.fault_level !== want.fault_level)
                  note_mismatch("fault_level", 64'(want.fault_level), 64'(rsp_mon.fault_level));
            end
         end
         if (req_mon.valid && req_mon.ready)
            walk_outcomes.push_back(walk_step(req_mon.req_type, req_mon.linear_address,
                                              req_mon.entry_data, req_mon.read_failed));
         if (csr_write_enable) begin
            case (csr_index)
               ptw_pkg::CSR_PAGING_ENABLED:  paging_on = csr_write_data[0];
               ptw_pkg::CSR_FIVE_LEVEL_MODE: five_level = csr_write_data[0];
               ptw_pkg::CSR_ROOT_FRAME:      root_pfn = csr_write_data[ptw_pkg::FRAME_BITS-1:0];
               default: ;
            endcase
         end
         outcomes_in_flight <= walk_outcomes.size();
      end
   end

endmodule

// ===== bench/tb_four_level_page_table_walker_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_core
// Drives translate requests and entry responses into the walker, with
// random gaps on both channels and several register settings; the checker
// beside the block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_core;

   localparam int         STALL_LIMIT     = 2000;
   localparam int         DRAIN_CYCLES    = 12;
   localparam int         HOLD_OFF_CYCLES = 64;
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [1:0]                        csr_index;
   logic [ptw_pkg::CSR_DATA_BITS-1:0] csr_write_data;
   int                                send_idle_pct;
   int                                recv_idle_pct;
   int                                mismatch_count;
   int                                outcomes_in_flight;
   int                                quiet_cycles;

   ptw_req_if req_bus ();
   ptw_rsp_if rsp_bus ();

   four_level_page_table_walker_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ptw_walk_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_bus),
      .rsp_mon            (rsp_bus),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .outcomes_in_flight (outcomes_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ptw_pkg::FRAME_BITS-1:0] small_frame();
      return ptw_pkg::FRAME_BITS'($urandom_range(32'h07ff_ffff));
   endfunction

   function automatic logic [63:0] make_entry(input logic [ptw_pkg::FRAME_BITS-1:0] pfn,
                                              input logic present, input logic big_page);
      logic [63:0] e;
      e = {$urandom, $urandom};
      e[51:12] = pfn;
      e[ptw_pkg::PRESENT_BIT] = present;
      e[ptw_pkg::LARGE_BIT] = big_page;
      return e;
   endfunction

   task automatic send_item(input ptw_pkg::req_kind_type kind, input logic [63:0] linear,
                            input logic [63:0] entry, input logic failed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.linear_address <= linear;
      req_bus.entry_data <= entry;
      req_bus.read_failed <= failed;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_translate(input logic [63:0] linear);
      send_item(ptw_pkg::REQ_TRANSLATE, linear, {$urandom, $urandom},
                1'($urandom_range(1)));
   endtask

   task automatic send_entry(input logic [63:0] entry, input logic failed);
      send_item(ptw_pkg::REQ_RESPONSE, {$urandom, $urandom}, entry, failed);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outcomes_in_flight != 0);
   endtask

   task automatic program_walker(input logic paging, input logic five,
                                 input logic [ptw_pkg::FRAME_BITS-1:0] root);
      csr_write_enable <= 1'b1;
      csr_index <= ptw_pkg::CSR_PAGING_ENABLED;
      csr_write_data <= ptw_pkg::CSR_DATA_BITS'({$urandom, $urandom, paging});
      @(posedge clock);
      csr_index <= ptw_pkg::CSR_FIVE_LEVEL_MODE;
      csr_write_data <= ptw_pkg::CSR_DATA_BITS'({$urandom, $urandom, five});
      @(posedge clock);
      csr_index <= ptw_pkg::CSR_ROOT_FRAME;
      csr_write_data <= root;
      @(posedge clock);
      csr_index <= CSR_SPARE_INDEX;
      csr_write_data <= ptw_pkg::CSR_DATA_BITS'({$urandom, $urandom});
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly whole walks with random entries, the rest stray beats
   task automatic run_segment(input int count);
      int sent;
      int pick;
      int depth;
      int extra;
      int k;
      logic ended;
      logic present;
      logic big_page;
      logic failed;
      logic [ptw_pkg::FRAME_BITS-1:0] pfn;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_translate({$urandom, $urandom});
            sent++;
            depth = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
            ended = 1'b0;
            for (k = 0; k < depth && !ended; k++) begin
               present = ($urandom_range(15) != 0);
               failed = ($urandom_range(31) == 0);
               big_page = ($urandom_range(2) == 0);
               pfn = ($urandom_range(19) == 0)
                     ? ptw_pkg::FRAME_BITS'({$urandom, $urandom}) : small_frame();
               send_entry(make_entry(pfn, present, big_page), failed);
               sent++;
               ended = !present || failed || (big_page && k != 0);
            end
         end else if (pick < 92) begin
            send_item(ptw_pkg::req_kind_type'($urandom_range(1)), {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom_range(1)));
            sent++;
         end else begin
            extra = $urandom_range(3, 1);
            for (k = 0; k < extra; k++) begin
               send_entry({$urandom, $urandom}, 1'($urandom_range(1)));
               sent++;
            end
         end
      end
   endtask

   initial begin : receiver
      int beats;
      int hold_mark;
      beats = 0;
      hold_mark = 400;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            beats++;
         if (beats == hold_mark) begin
            hold_mark += 900;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int seg;
      int len;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= ptw_pkg::REQ_TRANSLATE;
      req_bus.linear_address <= '0;
      req_bus.entry_data <= '0;
      req_bus.read_failed <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= ptw_pkg::CSR_PAGING_ENABLED;
      csr_write_data <= '0;
      send_idle_pct = 19;
      recv_idle_pct = 58;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_walker(1'b1, 1'b0, 40'h123);
      // response with no walk open
      send_entry(make_entry(40'h5, 1'b1, 1'b0), 1'b0);
      // full walk, large bit at the top ignored, all-ones leaf
      send_translate('1);
      send_entry(make_entry(small_frame(), 1'b1, 1'b1), 1'b0);
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry('1, 1'b0);
      // 1 GB page with high frame bits set
      send_translate({$urandom, $urandom});
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry(make_entry('1, 1'b1, 1'b1), 1'b0);
      // 2 MB page
      send_translate('0);
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry(make_entry(small_frame(), 1'b1, 1'b1), 1'b0);
      // not present at the directory level
      send_translate({$urandom, $urandom});
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_entry(make_entry(small_frame(), 1'b0, 1'b1), 1'b0);
      // failed read, then a restart mid-walk
      send_translate({$urandom, $urandom});
      send_entry('1, 1'b1);
      send_translate({$urandom, $urandom});
      send_entry(make_entry(small_frame(), 1'b1, 1'b0), 1'b0);
      send_translate('1);
      // last reachable entry, then a table past the limit
      send_entry(make_entry(40'h000_07ff_ffff, 1'b1, 1'b0), 1'b0);
      send_entry(make_entry(40'h000_0800_0000, 1'b1, 1'b0), 1'b0);

      wait_drained();
      program_walker(1'b0, 1'b0, small_frame());
      send_translate('1);
      wait_drained();
      program_walker(1'b0, 1'b1, small_frame());
      send_translate({$urandom, $urandom});
      wait_drained();
      program_walker(1'b1, 1'b0, '1);
      send_translate({$urandom, $urandom});

      for (seg = 0; seg < 9; seg++) begin
         wait_drained();
         send_idle_pct = (seg < 3) ? 19 : (seg < 6) ? 58 : 0;
         recv_idle_pct = (seg < 3) ? 58 : (seg < 6) ? 19 : 0;
         len = 280;
         case (seg)
            1: program_walker(1'b1, 1'b0, '0);
            2: begin
               program_walker(1'b0, 1'b0, small_frame());
               len = 60;
            end
            4: begin
               program_walker(1'b1, 1'b1, small_frame());
               len = 40;
            end
            5: program_walker(1'b1, 1'b0, 40'h000_07ff_ffff);
            6: begin
               program_walker(1'b1, 1'b0, '1);
               len = 40;
            end
            default: program_walker(1'b1, 1'b0, small_frame());
         endcase
         run_segment(len);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outcomes_in_flight == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ptw_pkg.sv
rtl/ptw_req_if.sv
rtl/ptw_rsp_if.sv
rtl/four_level_page_table_walker_core.sv
rtl/ptw_checker.sv
bench/ptw_walk_checker.sv
bench/tb_four_level_page_table_walker_core.sv
